// ===== sv/directory_signature_filter_defines.svh =====
// ----------------------------------------------------------------------------
// directory_signature_filter_defines
// Assertion macros used by the signature filter sequencer (dsf_ctrl).
// ----------------------------------------------------------------------------
`ifndef DIRECTORY_SIGNATURE_FILTER_DEFINES_SVH
`define DIRECTORY_SIGNATURE_FILTER_DEFINES_SVH

// same-cycle implication, off while reset is high
`define DSF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dsf: assertion failed");

// next-cycle implication, off while reset is high
`define DSF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dsf: assertion failed");

`endif

// ===== sv/dsf_pkg.sv =====
// ----------------------------------------------------------------------------
// dsf_pkg
// Types, codes, word layouts and the name hash of the signature filter.
// ----------------------------------------------------------------------------
package dsf_pkg;

   // request opcodes
   localparam logic [2:0] OP_OPEN   = 3'd0;
   localparam logic [2:0] OP_ADD    = 3'd1;
   localparam logic [2:0] OP_RECORD = 3'd2;
   localparam logic [2:0] OP_DONE   = 3'd3;
   localparam logic [2:0] OP_QUERY  = 3'd4;
   localparam logic [2:0] OP_TEST   = 3'd5;

   // scan kinds
   localparam logic [1:0] KIND_OTHER  = 2'd0;
   localparam logic [1:0] KIND_CREATE = 2'd1;
   localparam logic [1:0] KIND_MATCH  = 2'd2;
   localparam logic [1:0] KIND_NAME   = 2'd3;

   // query modes
   localparam logic [1:0] MODE_NONE   = 2'd0;
   localparam logic [1:0] MODE_FILTER = 2'd1;
   localparam logic [1:0] MODE_FREE   = 2'd2;

   // query check bits
   localparam int CHK_NAME_BIT = 0;
   localparam int CHK_USER_BIT = 1;
   localparam int CHK_EXT_BIT  = 2;

   // register indexes
   localparam logic [1:0] REG_LOGGED    = 2'd0;
   localparam logic [1:0] REG_REMOVABLE = 2'd1;
   localparam logic [1:0] REG_EXM       = 2'd2;

   localparam logic [7:0]  WILDCARD   = 8'h3F;
   localparam logic [7:0]  FREE_MARK  = 8'hE5;
   localparam logic [6:0]  CHAR_MASK  = 7'h7F;
   localparam logic [15:0] MODULE_CHK = 16'h3F00;
   localparam int          NAME_BYTES = 11;

   localparam int SLOT_W  = 10;
   localparam int DRIVE_W = 4;
   localparam int NAME_W  = 8 * NAME_BYTES;

   // request word layout
   localparam int REQ_TDATA_W = 128;
   localparam int REQ_TUSER_W = 5;
   localparam int DRIVE_LSB   = 0;
   localparam int SLOT_LSB    = 4;
   localparam int NAME_LSB    = 14;
   localparam int USER_LSB    = 102;
   localparam int EXT_LSB     = 110;
   localparam int MOD_LSB     = 118;
   localparam int OP_LSB      = 0;
   localparam int KIND_LSB    = 3;

   // response word layout
   localparam int RSP_TDATA_W = 8;

   typedef enum logic [0:0] {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      logic capture;   // latch request word, read its slot
      logic commit;    // apply the item, load the response register
   } cmd_type;

   typedef struct packed {
      logic [15:0] logged_drives;
      logic        removable_media;
      logic [7:0]  extent_mask;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  user_sig;
      logic [15:0] extent_sig;
      logic [15:0] name_sig;
   } entry_type;

   // rotate-xor hash: each byte ends up rotated left by 4 per later byte
   function automatic logic [15:0] name_hash(input logic [NAME_W-1:0] name);
      logic [15:0] h;
      logic [15:0] b;
      int          r;
      h = '0;
      for (int k = 0; k < NAME_BYTES; k++) begin
         b = {9'd0, name[8*k +: 7] & CHAR_MASK};
         r = (4 * (NAME_BYTES - 1 - k)) & 15;
         h = h ^ ((b << r) | (b >> (16 - r)));
      end
      return h;
   endfunction

   function automatic logic has_wildcard(input logic [NAME_W-1:0] name);
      logic w;
      w = 1'b0;
      for (int k = 0; k < NAME_BYTES; k++) begin
         w = w | (name[8*k +: 8] == WILDCARD);
      end
      return w;
   endfunction

endpackage

// ===== sv/dsf_csr.sv =====
// ----------------------------------------------------------------------------
// dsf_csr
// Register file behind the configuration port.
// ----------------------------------------------------------------------------
module dsf_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [3:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready,
   output dsf_pkg::cfg_type  cfg
);

   logic [15:0] logged_ff, logged_in;
   logic        removable_ff, removable_in;
   logic [7:0]  exm_ff, exm_in;
   logic        wr_en;
   logic [1:0]  reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[3:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      logged_in    = logged_ff;
      removable_in = removable_ff;
      exm_in       = exm_ff;
      csr_prdata   = '0;
      case (reg_idx)
         dsf_pkg::REG_LOGGED: begin
            if (wr_en) logged_in = csr_pwdata[15:0];
            csr_prdata = {16'd0, logged_ff};
         end
         dsf_pkg::REG_REMOVABLE: begin
            if (wr_en) removable_in = csr_pwdata[0];
            csr_prdata = {31'd0, removable_ff};
         end
         dsf_pkg::REG_EXM: begin
            if (wr_en) exm_in = csr_pwdata[7:0];
            csr_prdata = {24'd0, exm_ff};
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         logged_ff    <= '0;
         removable_ff <= 1'b0;
         exm_ff       <= '0;
      end else begin
         logged_ff    <= logged_in;
         removable_ff <= removable_in;
         exm_ff       <= exm_in;
      end
   end

   assign cfg.logged_drives   = logged_ff;
   assign cfg.removable_media = removable_ff;
   assign cfg.extent_mask     = exm_ff;

endmodule

// ===== sv/dsf_ctrl.sv =====
// ----------------------------------------------------------------------------
// dsf_ctrl
// Sequencer: takes one word, lets the table read settle, then commits it
// once the response register has room.
// ----------------------------------------------------------------------------
`include "directory_signature_filter_defines.svh"

module dsf_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output dsf_pkg::cmd_type cmd
);

   dsf_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dsf_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_tready  = 1'b0;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      case (state_ff)
         dsf_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = dsf_pkg::ST_EXEC;
            end
         end
         dsf_pkg::ST_EXEC: begin
            // hold until the previous word has left
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.commit = 1'b1;
               state_in   = dsf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dsf_pkg::ST_IDLE;
         end
      endcase
      if (cmd.commit) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;

   `DSF_ASSERT_NEXT(a_accept_to_exec, clock, reset, req_tvalid && req_tready, state_ff == dsf_pkg::ST_EXEC)
   `DSF_ASSERT_IMPL(a_commit_room, clock, reset, cmd.commit, !rsp_tvalid || rsp_tready)
   `DSF_ASSERT_NEXT(a_commit_shows, clock, reset, cmd.commit, rsp_tvalid && state_ff == dsf_pkg::ST_IDLE)

endmodule

// ===== sv/dsf_datapath.sv =====
// ----------------------------------------------------------------------------
// dsf_datapath
// Item register, signature table, table and query state, slot compare and
// response register.
// ----------------------------------------------------------------------------
module dsf_datapath #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  dsf_pkg::cmd_type                cmd,
   input  dsf_pkg::cfg_type                cfg,
   input  logic [dsf_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic [dsf_pkg::REQ_TUSER_W-1:0] req_tuser,
   output logic [dsf_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int EXT_W = ((AW > dsf_pkg::SLOT_W) ? AW : dsf_pkg::SLOT_W) + 1;

   // item register
   logic [2:0]                  op_ff;
   logic [1:0]                  kind_ff;
   logic [dsf_pkg::DRIVE_W-1:0] drive_ff;
   logic [dsf_pkg::SLOT_W-1:0]  slot_ff;
   logic [dsf_pkg::NAME_W-1:0]  name_ff;
   logic [7:0]                  user_ff;
   logic [7:0]                  ext_ff;
   logic [7:0]                  mod_ff;

   // table and query state
   logic        valid_ff, valid_in;
   logic        rebuild_ff, rebuild_in;
   logic [3:0]  tdrive_ff, tdrive_in;
   logic [1:0]  qmode_ff, qmode_in;
   logic [2:0]  qchecks_ff, qchecks_in;
   logic [15:0] qhash_ff, qhash_in;
   logic [7:0]  quser_ff, quser_in;
   logic [15:0] qext_ff, qext_in;
   logic [7:0]  qmask_ff, qmask_in;

   dsf_pkg::entry_type mem [TABLE_DEPTH];
   dsf_pkg::entry_type rd_data_ff;
   dsf_pkg::entry_type wr_data;
   logic               wr_en;

   logic [dsf_pkg::SLOT_W-1:0] req_slot;
   logic [EXT_W-1:0]           rd_idx, wr_idx;
   logic                       in_range;
   logic                       query_ok;
   logic                       cand;
   logic [15:0]                diff;
   logic [7:0]                 rsp_ff;

   assign req_slot = req_tdata[dsf_pkg::SLOT_LSB +: dsf_pkg::SLOT_W];
   assign rd_idx   = EXT_W'(req_slot);
   assign wr_idx   = EXT_W'(slot_ff);
   assign in_range = wr_idx < EXT_W'(TABLE_DEPTH);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff      <= req_tuser[dsf_pkg::OP_LSB +: 3];
         kind_ff    <= req_tuser[dsf_pkg::KIND_LSB +: 2];
         drive_ff   <= req_tdata[dsf_pkg::DRIVE_LSB +: dsf_pkg::DRIVE_W];
         slot_ff    <= req_slot;
         name_ff    <= req_tdata[dsf_pkg::NAME_LSB +: dsf_pkg::NAME_W];
         user_ff    <= req_tdata[dsf_pkg::USER_LSB +: 8];
         ext_ff     <= req_tdata[dsf_pkg::EXT_LSB +: 8];
         mod_ff     <= req_tdata[dsf_pkg::MOD_LSB +: 8];
         rd_data_ff <= mem[rd_idx[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && wr_en) begin
         mem[wr_idx[AW-1:0]] <= wr_data;
      end
   end

   assign wr_data.user_sig   = user_ff;
   assign wr_data.extent_sig = {mod_ff, ext_ff};
   assign wr_data.name_sig   = dsf_pkg::name_hash(name_ff);

   assign query_ok = valid_ff && (tdrive_ff == drive_ff) &&
                     cfg.logged_drives[tdrive_ff] && !cfg.removable_media;

   // slot test against the active query
   always_comb begin
      diff = rd_data_ff.extent_sig ^ qext_ff;
      if (qmode_ff != dsf_pkg::MODE_FILTER && qmode_ff != dsf_pkg::MODE_FREE) begin
         cand = 1'b1;
      end else if (!in_range) begin
         cand = 1'b1;
      end else if (qmode_ff == dsf_pkg::MODE_FREE) begin
         cand = (rd_data_ff.user_sig == dsf_pkg::FREE_MARK);
      end else begin
         cand = (rd_data_ff.name_sig == qhash_ff);
         if (qchecks_ff[dsf_pkg::CHK_USER_BIT] &&
             ((rd_data_ff.user_sig[6:0] ^ quser_ff[6:0]) != 7'd0)) begin
            cand = 1'b0;
         end
         if (qchecks_ff[dsf_pkg::CHK_EXT_BIT] &&
             (((diff[7:0] & qmask_ff) != 8'd0) ||
              ((diff & dsf_pkg::MODULE_CHK) != 16'd0))) begin
            cand = 1'b0;
         end
      end
   end

   always_comb begin
      valid_in   = valid_ff;
      rebuild_in = rebuild_ff;
      tdrive_in  = tdrive_ff;
      qmode_in   = qmode_ff;
      qchecks_in = qchecks_ff;
      qhash_in   = qhash_ff;
      quser_in   = quser_ff;
      qext_in    = qext_ff;
      qmask_in   = qmask_ff;
      wr_en      = 1'b0;
      case (op_ff)
         dsf_pkg::OP_OPEN: begin
            if (cfg.removable_media) begin
               valid_in   = 1'b0;
               rebuild_in = 1'b0;
            end else if (!(valid_ff && tdrive_ff == drive_ff)) begin
               valid_in   = 1'b0;
               tdrive_in  = drive_ff;
               rebuild_in = 1'b1;
            end
         end
         dsf_pkg::OP_ADD: begin
            wr_en = rebuild_ff && in_range;
         end
         dsf_pkg::OP_RECORD: begin
            wr_en = (valid_ff || rebuild_ff) && (tdrive_ff == drive_ff) && in_range;
         end
         dsf_pkg::OP_DONE: begin
            if (rebuild_ff) begin
               valid_in   = 1'b1;
               rebuild_in = 1'b0;
            end
         end
         dsf_pkg::OP_QUERY: begin
            qmode_in   = dsf_pkg::MODE_NONE;
            qchecks_in = '0;
            if (query_ok) begin
               if (kind_ff == dsf_pkg::KIND_CREATE) begin
                  qmode_in = dsf_pkg::MODE_FREE;
               end else if (kind_ff != dsf_pkg::KIND_OTHER &&
                            !dsf_pkg::has_wildcard(name_ff)) begin
                  qhash_in = wr_data.name_sig;
                  qchecks_in[dsf_pkg::CHK_NAME_BIT] = 1'b1;
                  if (user_ff != dsf_pkg::WILDCARD) begin
                     quser_in = user_ff;
                     qchecks_in[dsf_pkg::CHK_USER_BIT] = 1'b1;
                  end
                  if (kind_ff == dsf_pkg::KIND_MATCH && ext_ff != dsf_pkg::WILDCARD) begin
                     qext_in  = {mod_ff, ext_ff};
                     qmask_in = ~cfg.extent_mask;
                     qchecks_in[dsf_pkg::CHK_EXT_BIT] = 1'b1;
                  end
                  qmode_in = dsf_pkg::MODE_FILTER;
               end
            end
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         rebuild_ff <= 1'b0;
         tdrive_ff  <= '0;
         qmode_ff   <= dsf_pkg::MODE_NONE;
         qchecks_ff <= '0;
         qhash_ff   <= '0;
         quser_ff   <= '0;
         qext_ff    <= '0;
         qmask_ff   <= '0;
      end else if (cmd.commit) begin
         valid_ff   <= valid_in;
         rebuild_ff <= rebuild_in;
         tdrive_ff  <= tdrive_in;
         qmode_ff   <= qmode_in;
         qchecks_ff <= qchecks_in;
         qhash_ff   <= qhash_in;
         quser_ff   <= quser_in;
         qext_ff    <= qext_in;
         qmask_ff   <= qmask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff <= {5'd0, (op_ff == dsf_pkg::OP_TEST) && cand, qmode_in};
      end
   end

   assign rsp_tdata = rsp_ff;

endmodule

// ===== sv/directory_signature_filter.sv =====
// ----------------------------------------------------------------------------
// directory_signature_filter
// Directory signature table with query and slot-test filtering.
// ----------------------------------------------------------------------------
// Usage: requests enter on the req_ stream, one word per opcode (open drive,
// login add, record write, login done, start query, test slot). Every
// request gives exactly one word on the rsp_ stream: the query mode after
// the request and, for a slot test, the candidate flag.
// A taken request is captured with its table slot read, then committed once
// the response register has room. The signature table read is registered,
// so each request passes through capture/read and then commit; no new
// request is taken until the last one has committed.
// A response waits in its output register while the receiver stalls; the
// next request is still taken, and its commit holds until that word leaves.
// Reset clears the table state, the query state, the registers and the
// response valid; table entries read as unknown until written.
// Registers on csr_ (APB): logged_drives at 0x0, removable_media at 0x4,
// extent_mask at 0x8. Write them only while the block is idle.
// ----------------------------------------------------------------------------
module directory_signature_filter #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // drive[3:0], slot_index[13:4], name_low[77:14], name_high[101:78],
   // user_byte[109:102], extent_byte[117:110], module_byte[125:118], zero
   input  logic [127:0]  req_tdata,
   // opcode[2:0], scan_kind[4:3]
   input  logic [4:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // scan_mode[1:0], candidate[2], zero
   output logic [7:0]    rsp_tdata,
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [3:0]    csr_paddr,
   input  logic [31:0]   csr_pwdata,
   output logic [31:0]   csr_prdata,
   output logic          csr_pready
);

   dsf_pkg::cmd_type cmd;
   dsf_pkg::cfg_type cfg;

   dsf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   dsf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   dsf_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cfg       (cfg),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata)
   );

endmodule
